[rtl/hxf_pkg.sv]
// Shared types, state encoding and character helpers for the hex field formatter.
package hxf_pkg;

  // One formatting request
  typedef struct packed {
    logic [31:0]       value;
    logic              upper_case;
    logic [6:0]        min_width;
    logic signed [7:0] precision;
    logic              has_point;
    logic              zero_flag;
    logic              left_align;
  } in_item_t;

  // One emitted character
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } hxf_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic calc;  // latch segment boundaries, clear position
    logic adv;   // step to the next character
  } hxf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty; // field has no characters
    logic last;  // current position is the final character
  } hxf_status_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  // ASCII for one hex nibble
  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CHAR_ZERO + {4'b0, nib};
    end else begin
      res = (upper ? CHAR_UP_A : CHAR_LOW_A) + {4'b0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

[rtl/hxf_ctrl.sv]
// Controller state machine: accept, compute layout, emit characters.
module hxf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  hxf_pkg::hxf_status_t status,
  output hxf_pkg::hxf_cmd_t    cmd
);
  import hxf_pkg::*;

  hxf_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_stall   = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = status.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          cmd.adv = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/hxf_dp.sv]
// Datapath: transaction register, field layout and character generation.
module hxf_dp #(
  parameter int MAX_FIELD = 64
) (
  input  logic                 clk,
  input  hxf_pkg::in_item_t    item,
  input  hxf_pkg::hxf_cmd_t    cmd,
  output hxf_pkg::hxf_status_t status,
  output hxf_pkg::out_item_t   result
);
  import hxf_pkg::*;

  localparam int CW = $clog2(MAX_FIELD + 1);
  localparam logic signed [8:0] MaxS = 9'(MAX_FIELD);

  in_item_t      cur;
  logic [CW-1:0] b1, b2, total, dig_end, pos;

  // Layout computed from the captured transaction
  logic [3:0]        nd;
  logic signed [8:0] prec, wid, nds, zr, sp, zc, sc;
  logic signed [8:0] c_b1, c_b2, c_total, c_dend;

  always_comb begin
    // significant digit count
    nd = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (cur.value[4*i +: 4] != 4'd0) begin
        nd = 4'(i + 1);
      end
    end
    prec = {cur.precision[7], cur.precision};
    if (prec > MaxS) begin
      prec = MaxS;
    end
    wid = {2'b00, cur.min_width};
    if (wid > MaxS) begin
      wid = MaxS;
    end
    nds = {5'b0, nd};
    zr  = (prec >= nds) ? prec - nds : 9'sd0;
    // zero value with explicit zero precision prints no digits
    if (cur.has_point && cur.value == 32'd0 && prec == 9'sd0) begin
      nds = 9'sd0;
    end
    sp = wid - (zr + nds);
    if (cur.zero_flag && (!cur.has_point || prec < 9'sd0)) begin
      zr = sp;
      sp = 9'sd0;
    end
    zc = (zr < 9'sd0) ? 9'sd0 : zr;
    sc = (sp < 9'sd0) ? 9'sd0 : sp;
    if (cur.left_align) begin
      c_b1    = zc;
      c_b2    = zc + nds;
      c_total = c_b2 + sc;
      c_dend  = c_b2;
    end else begin
      c_b1    = sc;
      c_b2    = sc + zc;
      c_total = c_b2 + nds;
      c_dend  = c_total;
    end
  end

  assign status.empty = (c_total == 9'sd0);

  // Transaction and layout registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.calc) begin
      b1      <= c_b1[CW-1:0];
      b2      <= c_b2[CW-1:0];
      total   <= c_total[CW-1:0];
      dig_end <= c_dend[CW-1:0];
      pos     <= '0;
    end else if (cmd.adv) begin
      pos <= pos + 1'b1;
    end
  end

  assign status.last = (pos == total - 1'b1);

  // Character at the current position
  logic [CW-1:0] didx_full;
  logic [2:0]    didx;
  logic [7:0]    dchar;

  always_comb begin
    didx_full = dig_end - pos - 1'b1;
    didx      = didx_full[2:0];
    dchar     = hex_char(cur.value[{didx, 2'b00} +: 4], cur.upper_case);
    if (pos < b1) begin
      result.out_char = cur.left_align ? CHAR_ZERO : CHAR_SPACE;
    end else if (pos < b2) begin
      result.out_char = cur.left_align ? dchar : CHAR_ZERO;
    end else begin
      result.out_char = cur.left_align ? CHAR_SPACE : dchar;
    end
    result.last_char = status.last;
  end

endmodule

[rtl/hex_field_formatter.sv]
// hex_field_formatter: printf-style hex field, one ASCII character per transaction out.
// A transaction in is captured, the field is then laid out in the calc state,
// and the field streams out at one character per cycle while the result side
// does not stall: N characters per item, N being the field length (0 to
// MAX_FIELD). The character counter of the emit loop counts them; a new
// item is taken once the last character has left. Empty fields emit nothing.
module hex_field_formatter #(
  parameter int MAX_FIELD = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  hxf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output hxf_pkg::out_item_t result
);
  import hxf_pkg::*;

  hxf_cmd_t    cmd;
  hxf_status_t status;

  // Sequencer
  hxf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Layout and character generation
  hxf_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
